/* design/rsr_pkg.sv */
// Package with the item types, kind codes and constants of the sprite row decoder.
`default_nettype none

package rsr_pkg;

    localparam int MAX_DIM_DEFAULT = 4096;
    localparam int HDR_LEN         = 24;
    localparam int HDR_BOUND_START = 8;
    localparam int COL_W           = 22;
    localparam int RUN_W           = 7;
    localparam logic [63:0] AREA_MAX = 64'd16777216;

    localparam logic [1:0] KIND_HEADER = 2'd0;
    localparam logic [1:0] KIND_RUN    = 2'd1;
    localparam logic [1:0] KIND_DONE   = 2'd2;
    localparam logic [1:0] KIND_ERROR  = 2'd3;

    typedef enum logic [2:0] {
        PH_IDLE    = 3'd0,
        PH_HEADER  = 3'd1,
        PH_OPCODE  = 3'd2,
        PH_SKIP    = 3'd3,
        PH_FILL    = 3'd4,
        PH_LITERAL = 3'd5
    } phase_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       first;
    } in_item_t;

    typedef struct packed {
        logic [1:0]         kind;
        logic [11:0]        row;
        logic [11:0]        column;
        logic [6:0]         run_length;
        logic [7:0]         color;
        logic [12:0]        width;
        logic [12:0]        height;
        logic signed [31:0] left_bound;
        logic signed [31:0] top_bound;
    } out_item_t;

endpackage

`default_nettype wire

/* design/rle_sprite_row_decoder.sv */
// Top level of the run-length sprite row decoder: header parse, opcode decode and result queue.
`default_nettype none

// The decoder takes one shape byte per cycle and answers each byte with at most one
// result, which reaches the output register in the cycle after the byte was taken, or
// the skid register behind it while an earlier result still waits there. The output
// register and the skid register decouple the two sides, so input keeps flowing
// at one byte per cycle while a result waits; in_ready drops only when both are full.
// The header check is split so that the width and the partial height are registered
// while the header streams in, and the last header byte only adds its top byte and
// does one DIM_W-wide multiply against the area limit.
module rle_sprite_row_decoder
    import rsr_pkg::*;
#(
    parameter int MAX_DIM = MAX_DIM_DEFAULT
)(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output logic           in_ready,
    input  wire in_item_t  in_data,
    output logic           out_valid,
    input  wire logic      out_ready,
    output out_item_t      out_data
);

    localparam int DIM_W = $clog2(MAX_DIM + 1);
    localparam int LIM_W = DIM_W + 2;
    localparam int AREA_W = 2 * DIM_W;
    localparam logic [COL_W-1:0] COL_MAX = {COL_W{1'b1}};
    localparam logic signed [33:0] W_MAX_S = 34'(MAX_DIM);
    localparam logic signed [35:0] H_MAX_S = 36'(MAX_DIM);

    phase_t                 phase_reg, phase_next;
    logic [4:0]             hcount_reg, hcount_next;
    logic [3:0][31:0]       bound_reg, bound_next;
    logic [DIM_W-1:0]       cur_row_reg, cur_row_next;
    logic [COL_W-1:0]       cur_col_reg, cur_col_next;
    logic [RUN_W-1:0]       run_left_reg, run_left_next;
    logic [LIM_W-1:0]       op_count_reg, op_count_next;
    logic [LIM_W-1:0]       limit_reg, limit_next;
    logic [DIM_W-1:0]       spr_w_reg, spr_w_next;
    logic [DIM_W-1:0]       spr_h_reg, spr_h_next;
    logic signed [33:0]     w_reg, w_next;
    logic signed [33:0]     d_reg, d_next;

    logic                   out_valid_reg, out_valid_next;
    out_item_t              out_data_reg, out_data_next;
    logic                   skid_valid_reg, skid_valid_next;
    out_item_t              skid_data_reg, skid_data_next;

    logic                   accept;
    logic                   res_valid;
    out_item_t              res;

    assign accept    = in_valid && in_ready;
    assign in_ready  = !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Byte merge into the bound words; the width and partial height follow it.
    always_comb
    begin
        logic [3:0] k;
        bound_next = bound_reg;
        k = 4'd0;
        if (accept)
        begin
            if (in_data.first)
            begin
                bound_next = '0;
            end
            if ((in_data.first || phase_reg == PH_HEADER) &&
                (in_data.first ? 5'd0 : hcount_reg) >= 5'(HDR_BOUND_START) &&
                (in_data.first ? 5'd0 : hcount_reg) <  5'(HDR_LEN))
            begin
                k = 4'(hcount_reg - 5'(HDR_BOUND_START));
                bound_next[k[3:2]][k[1:0]*8 +: 8] = in_data.data_byte;
            end
        end
        w_next = $signed({{2{bound_next[2][31]}}, bound_next[2]})
               - $signed({{2{bound_next[0][31]}}, bound_next[0]}) + 34'sd1;
        d_next = $signed({10'b0, bound_next[3][23:0]})
               - $signed({{2{bound_next[1][31]}}, bound_next[1]}) + 34'sd1;
    end

    always_comb
    begin
        phase_t                  ph;
        logic [7:0]              b;
        logic signed [35:0]      h_full;
        logic [AREA_W-1:0]       area;
        logic                    hdr_ok;
        logic [DIM_W-1:0]        row_inc;
        logic [COL_W:0]          col_sum;
        logic [RUN_W-1:0]        count;
        logic [COL_W-1:0]        span;

        phase_next    = phase_reg;
        hcount_next   = hcount_reg;
        cur_row_next  = cur_row_reg;
        cur_col_next  = cur_col_reg;
        run_left_next = run_left_reg;
        op_count_next = op_count_reg;
        limit_next    = limit_reg;
        spr_w_next    = spr_w_reg;
        spr_h_next    = spr_h_reg;
        res_valid     = 1'b0;
        res           = '0;

        b       = in_data.data_byte;
        ph      = in_data.first ? PH_HEADER : phase_reg;
        h_full  = $signed({{2{d_reg[33]}}, d_reg}) + $signed({{4{b[7]}}, b, 24'b0});
        area    = w_reg[DIM_W-1:0] * d_reg[DIM_W-1:0];
        hdr_ok  = !w_reg[33] && (w_reg != 34'sd0) && (w_reg <= W_MAX_S) &&
                  !h_full[35] && (h_full != 36'sd0) && (h_full <= H_MAX_S) &&
                  !({{(64-AREA_W){1'b0}}, area} > AREA_MAX);
        row_inc = cur_row_reg + DIM_W'(1);
        col_sum = '0;
        count   = '0;
        span    = COL_W'(spr_w_reg) - cur_col_reg;

        if (accept)
        begin
            unique case (ph) inside
                PH_HEADER:
                begin
                    hcount_next = (in_data.first ? 5'd0 : hcount_reg) + 5'd1;
                    if (hcount_next >= 5'(HDR_LEN))
                    begin
                        res_valid = 1'b1;
                        if (hdr_ok)
                        begin
                            spr_w_next    = w_reg[DIM_W-1:0];
                            spr_h_next    = h_full[DIM_W-1:0];
                            limit_next    = LIM_W'({w_reg[DIM_W-1:0], 1'b0}) + LIM_W'(8);
                            cur_row_next  = '0;
                            cur_col_next  = '0;
                            op_count_next = '0;
                            run_left_next = '0;
                            phase_next    = PH_OPCODE;
                            res.kind       = KIND_HEADER;
                            res.width      = 13'(w_reg[DIM_W-1:0]);
                            res.height     = 13'(h_full[DIM_W-1:0]);
                            res.left_bound = bound_reg[0];
                            res.top_bound  = bound_reg[1];
                        end
                        else
                        begin
                            phase_next = PH_IDLE;
                            res.kind   = KIND_ERROR;
                        end
                    end
                    else
                    begin
                        phase_next = PH_HEADER;
                    end
                end
                PH_OPCODE:
                begin
                    if (op_count_reg > limit_reg)
                    begin
                        phase_next = PH_IDLE;
                        res_valid  = 1'b1;
                        res.kind   = KIND_ERROR;
                    end
                    else if (b == 8'd0)
                    begin
                        cur_row_next  = row_inc;
                        cur_col_next  = '0;
                        op_count_next = '0;
                        if (row_inc >= spr_h_reg)
                        begin
                            phase_next = PH_IDLE;
                            res_valid  = 1'b1;
                            res.kind   = KIND_DONE;
                        end
                    end
                    else
                    begin
                        op_count_next = op_count_reg + LIM_W'(1);
                        run_left_next = b[7:1];
                        if (b == 8'd1)
                        begin
                            phase_next = PH_SKIP;
                        end
                        else if (b[0])
                        begin
                            phase_next = PH_LITERAL;
                        end
                        else
                        begin
                            phase_next = PH_FILL;
                        end
                    end
                end
                PH_SKIP, PH_FILL, PH_LITERAL:
                begin
                    if (ph == PH_SKIP)
                    begin
                        col_sum = {1'b0, cur_col_reg} + (COL_W + 1)'(b);
                    end
                    else if (ph == PH_FILL)
                    begin
                        count   = run_left_reg;
                        col_sum = {1'b0, cur_col_reg} + (COL_W + 1)'(run_left_reg);
                    end
                    else
                    begin
                        count   = RUN_W'(1);
                        col_sum = {1'b0, cur_col_reg} + (COL_W + 1)'(1);
                    end
                    cur_col_next = col_sum[COL_W] ? COL_MAX : col_sum[COL_W-1:0];

                    // Pixels at or past the right edge are dropped, but the column still moves.
                    if (ph != PH_SKIP && cur_col_reg < COL_W'(spr_w_reg))
                    begin
                        res_valid      = 1'b1;
                        res.kind       = KIND_RUN;
                        res.row        = 12'(cur_row_reg);
                        res.column     = cur_col_reg[11:0];
                        res.run_length = (span > COL_W'(count)) ? count : span[RUN_W-1:0];
                        res.color      = b;
                    end

                    if (ph == PH_LITERAL && run_left_reg > RUN_W'(1))
                    begin
                        run_left_next = run_left_reg - RUN_W'(1);
                        phase_next    = PH_LITERAL;
                    end
                    else
                    begin
                        run_left_next = '0;
                        phase_next    = PH_OPCODE;
                    end
                end
                default:
                begin
                    phase_next = PH_IDLE;
                end
            endcase
        end
    end

    // Output register with one skid entry behind it.
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (!out_valid_reg || out_ready)
        begin
            if (skid_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = res_valid;
                out_data_next  = res;
            end
        end
        else if (res_valid)
        begin
            skid_valid_next = 1'b1;
            skid_data_next  = res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_IDLE;
            hcount_reg     <= '0;
            bound_reg      <= '0;
            cur_row_reg    <= '0;
            cur_col_reg    <= '0;
            run_left_reg   <= '0;
            op_count_reg   <= '0;
            limit_reg      <= '0;
            spr_w_reg      <= '0;
            spr_h_reg      <= '0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg      <= phase_next;
            hcount_reg     <= hcount_next;
            bound_reg      <= bound_next;
            cur_row_reg    <= cur_row_next;
            cur_col_reg    <= cur_col_next;
            run_left_reg   <= run_left_next;
            op_count_reg   <= op_count_next;
            limit_reg      <= limit_next;
            spr_w_reg      <= spr_w_next;
            spr_h_reg      <= spr_h_next;
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        w_reg         <= w_next;
        d_reg         <= d_next;
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

endmodule

`default_nettype wire

/* sim/tb_rle_sprite_row_decoder.sv */
// Self-checking testbench for the run-length sprite row decoder.
`timescale 1ns / 1ps

module tb_rle_sprite_row_decoder;
    import rsr_pkg::*;

    localparam logic [7:0] OP_END = 8'd0;
    localparam logic [7:0] OP_SKIP = 8'd1;
    localparam int unsigned COL_LIMIT = (1 << COL_W) - 1;
    localparam int LONG_HOLD = 300;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    in_item_t in_data = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    out_item_t out_data;

    // Decoder state as the testbench sees it.
    phase_t dec_phase = PH_IDLE;
    int unsigned hdr_count = 0;
    logic [127:0] bounds_le = '0;
    int unsigned row_idx = 0;
    int unsigned col_pos = 0;
    int unsigned run_left = 0;
    int unsigned ops_in_row = 0;
    int unsigned spr_w = 0;
    int unsigned spr_h = 0;

    out_item_t pending_decodes[$];
    int error_count = 0;
    int bytes_taken = 0;
    int results_seen[4] = '{default: 0};
    int in_idle_pct = 0;
    int out_idle_pct = 0;
    int holds_asked = 0;
    int holds_granted = 0;
    int hold_left = 0;

    rle_sprite_row_decoder dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("TB_ERROR");
        $finish;
    end

    function automatic void advance_col(input int unsigned n);
        col_pos += n;
        if (col_pos > COL_LIMIT)
            col_pos = COL_LIMIT;
    endfunction

    // A run that starts at or beyond the right edge is dropped entirely.
    function automatic bit clip_run(input int unsigned count, input logic [7:0] color,
                                    output out_item_t res);
        int unsigned len;
        res = '0;
        if (col_pos >= spr_w)
            return 1'b0;
        len = spr_w - col_pos;
        if (len > count)
            len = count;
        res.kind = KIND_RUN;
        res.row = 12'(row_idx);
        res.column = 12'(col_pos);
        res.run_length = 7'(len);
        res.color = color;
        return 1'b1;
    endfunction

    function automatic bit decode_byte(input in_item_t item, output out_item_t res);
        logic [7:0] b;
        longint x0, y0, w, h;
        bit has;
        b = item.data_byte;
        res = '0;
        if (item.first)
        begin
            dec_phase = PH_HEADER;
            hdr_count = 0;
            bounds_le = '0;
        end
        case (dec_phase)
            PH_HEADER:
            begin
                if (hdr_count >= HDR_BOUND_START && hdr_count < HDR_LEN)
                    bounds_le[8 * (hdr_count - HDR_BOUND_START) +: 8] = b;
                hdr_count++;
                if (hdr_count < HDR_LEN)
                    return 1'b0;
                x0 = $signed(bounds_le[31:0]);
                y0 = $signed(bounds_le[63:32]);
                w = longint'($signed(bounds_le[95:64])) - x0 + 1;
                h = longint'($signed(bounds_le[127:96])) - y0 + 1;
                if (w <= 0 || h <= 0 || w > MAX_DIM_DEFAULT || h > MAX_DIM_DEFAULT
                    || w * h > longint'(AREA_MAX))
                begin
                    dec_phase = PH_IDLE;
                    res.kind = KIND_ERROR;
                    return 1'b1;
                end
                spr_w = int'(w);
                spr_h = int'(h);
                row_idx = 0;
                col_pos = 0;
                ops_in_row = 0;
                run_left = 0;
                dec_phase = PH_OPCODE;
                res.kind = KIND_HEADER;
                res.width = 13'(spr_w);
                res.height = 13'(spr_h);
                res.left_bound = bounds_le[31:0];
                res.top_bound = bounds_le[63:32];
                return 1'b1;
            end
            PH_OPCODE:
            begin
                if (ops_in_row > spr_w * 2 + 8)
                begin
                    dec_phase = PH_IDLE;
                    res.kind = KIND_ERROR;
                    return 1'b1;
                end
                ops_in_row++;
                if (b == OP_END)
                begin
                    row_idx++;
                    col_pos = 0;
                    ops_in_row = 0;
                    if (row_idx >= spr_h)
                    begin
                        dec_phase = PH_IDLE;
                        res.kind = KIND_DONE;
                        return 1'b1;
                    end
                    return 1'b0;
                end
                if (b == OP_SKIP)
                begin
                    dec_phase = PH_SKIP;
                    return 1'b0;
                end
                run_left = b >> 1;
                dec_phase = b[0] ? PH_LITERAL : PH_FILL;
                return 1'b0;
            end
            PH_SKIP:
            begin
                advance_col(b);
                dec_phase = PH_OPCODE;
                return 1'b0;
            end
            PH_FILL:
            begin
                has = clip_run(run_left, b, res);
                advance_col(run_left);
                run_left = 0;
                dec_phase = PH_OPCODE;
                return has;
            end
            PH_LITERAL:
            begin
                has = clip_run(1, b, res);
                advance_col(1);
                if (run_left > 0)
                    run_left--;
                if (run_left == 0)
                    dec_phase = PH_OPCODE;
                return has;
            end
            default:
            begin
                dec_phase = PH_IDLE;
                return 1'b0;
            end
        endcase
    endfunction

    // Entered at a falling edge; returns at the falling edge after the item was taken.
    task automatic send_byte(input logic [7:0] b, input logic f);
        in_item_t item;
        out_item_t res;
        item.data_byte = b;
        item.first = f;
        while ($urandom_range(99) < in_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data <= item;
        do
            @(posedge clk);
        while (!in_ready);
        if (decode_byte(item, res))
            pending_decodes = {pending_decodes, res};
        bytes_taken++;
        @(negedge clk);
    endtask

    task automatic send_header(input logic [31:0] x0, input logic [31:0] y0,
                               input logic [31:0] x1, input logic [31:0] y1);
        logic [127:0] words;
        words = {y1, x1, y0, x0};
        send_byte(8'($urandom), 1'b1);
        for (int i = 1; i < HDR_BOUND_START; i++)
            send_byte(8'($urandom), 1'b0);
        for (int i = 0; i < 16; i++)
            send_byte(words[8 * i +: 8], 1'b0);
    endtask

    task automatic send_fill(input int n, input logic [7:0] color);
        send_byte(8'(2 * n), 1'b0);
        send_byte(color, 1'b0);
    endtask

    task automatic send_literal(input int k);
        send_byte(8'(2 * k + 1), 1'b0);
        repeat (k) send_byte(8'($urandom), 1'b0);
    endtask

    task automatic send_skip(input logic [7:0] n);
        send_byte(OP_SKIP, 1'b0);
        send_byte(n, 1'b0);
    endtask

    task automatic test_idle_bytes();
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hA5, 1'b0);
    endtask

    task automatic test_bad_headers();
        send_header(32'd5, 32'd0, 32'd4, 32'd0);
        send_header(32'd0, 32'd7, 32'd0, 32'd6);
        send_header(32'd0, 32'd0, 32'd4096, 32'd0);
        send_header(32'd0, 32'd0, 32'd0, 32'd4096);
        send_header(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_header(32'h7FFF_FFFF, 32'd0, 32'h8000_0000, 32'd0);
    endtask

    // An 8 by 3 sprite: every opcode type, clipping and a fully clipped literal.
    task automatic test_full_shape();
        send_header(32'hFFFF_FFFD, 32'd10, 32'd4, 32'd12);
        send_fill(3, 8'hFF);
        send_literal(2);
        send_skip(8'd1);
        send_fill(127, 8'h00);
        send_literal(1);
        send_byte(OP_END, 1'b0);
        send_byte(OP_END, 1'b0);
        send_skip(8'd255);
        send_fill(4, 8'hAA);
        send_skip(8'd0);
        send_byte(OP_END, 1'b0);
    endtask

    // Width 1 allows eleven opcodes in a row; the twelfth is rejected.
    task automatic test_op_limit();
        send_header(32'd0, 32'd0, 32'd0, 32'd1);
        repeat (10) send_skip(8'd0);
        send_byte(OP_END, 1'b0);
        repeat (11) send_skip(8'd0);
        send_byte(OP_END, 1'b0);
    endtask

    task automatic test_restart();
        send_byte(8'h12, 1'b1);
        repeat (5) send_byte(8'($urandom), 1'b0);
        send_header(32'd0, 32'd0, 32'd3, 32'd1);
        send_fill(2, 8'h3C);
        send_byte(8'd6, 1'b0);
        send_header(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0, 32'd0);
        send_literal(3);
        send_byte(OP_END, 1'b0);
        send_byte(OP_END, 1'b0);
    endtask

    task automatic test_max_dims();
        send_header(32'h8000_0000, 32'h7FFF_F000, 32'h8000_0FFF, 32'h7FFF_FFFF);
        send_fill(127, 8'hFF);
        repeat (15) send_skip(8'd255);
        send_fill(127, 8'h81);
        send_fill(127, 8'h7E);
        send_byte(OP_END, 1'b0);
        send_header(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_literal(1);
        send_byte(OP_END, 1'b0);
    endtask

    // The receiver stops for a long stretch while a run-heavy row keeps arriving.
    task automatic test_backpressure();
        int saved_pct;
        saved_pct = in_idle_pct;
        in_idle_pct = 0;
        holds_asked++;
        send_header(32'd0, 32'd0, 32'd15, 32'd0);
        repeat (40) send_fill(1, 8'($urandom));
        send_byte(OP_END, 1'b0);
        in_idle_pct = saved_pct;
    endtask

    task automatic random_shape();
        int unsigned w, h, pick, nops;
        logic [31:0] x0, y0;
        pick = $urandom_range(99);
        if (pick < 5)
        begin
            repeat ($urandom_range(1, 4)) send_byte(8'($urandom), 1'b0);
            return;
        end
        if (pick < 75)
            w = $urandom_range(1, 12);
        else if (pick < 93)
            w = $urandom_range(13, 140);
        else
            w = $urandom_range(3000, MAX_DIM_DEFAULT);
        h = (w > 140) ? 1 : $urandom_range(1, 4);
        x0 = ($urandom_range(7) == 0) ? $urandom : 32'($urandom_range(2000)) - 32'd1000;
        y0 = ($urandom_range(7) == 0) ? $urandom : 32'($urandom_range(2000)) - 32'd1000;
        if ($urandom_range(99) < 8)
            send_header(x0, y0, $urandom, $urandom);
        else
            send_header(x0, y0, x0 + w - 1, y0 + h - 1);
        for (int r = 0; r < h; r++)
        begin
            nops = $urandom_range(0, 5);
            for (int i = 0; i <= nops; i++)
            begin
                if (dec_phase != PH_OPCODE)
                    return;
                pick = $urandom_range(99);
                if (i == nops)
                    send_byte(OP_END, 1'b0);
                else if (pick < 3)
                begin
                    // Abandon the shape in the middle of a run.
                    send_byte(8'($urandom_range(2, 255)), 1'b0);
                    return;
                end
                else if (pick < 5 && w <= 12)
                begin
                    repeat (2 * w + 10) send_skip(8'd0);
                    return;
                end
                else if (pick < 50)
                    send_fill(pick < 12 ? $urandom_range(1, 127)
                                        : $urandom_range(1, (w + 2 > 127) ? 127 : w + 2),
                              8'($urandom));
                else if (pick < 80)
                    send_literal(pick < 53 ? $urandom_range(5, 127) : $urandom_range(1, 4));
                else
                    send_skip(pick < 88 ? 8'($urandom) : 8'($urandom_range(0, 3)));
            end
        end
    endtask

    task automatic test_random(input int tx_pct, input int rx_pct, input int n_items);
        int stop_at;
        in_idle_pct = tx_pct;
        out_idle_pct = rx_pct;
        stop_at = bytes_taken + n_items;
        while (bytes_taken < stop_at)
            random_shape();
    endtask

    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            out_ready <= 1'b0;
        end
        else if (holds_granted != holds_asked)
        begin
            holds_granted <= holds_granted + 1;
            hold_left <= LONG_HOLD;
            out_ready <= 1'b0;
        end
        else
            out_ready <= ($urandom_range(99) >= out_idle_pct);
    end

    function automatic void check_field(input string name, input longint want,
                                        input longint got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            error_count++;
        end
    endfunction

    always @(posedge clk)
    begin
        out_item_t want;
        if (rst_n && out_valid && out_ready)
        begin
            results_seen[out_data.kind]++;
            if (pending_decodes.size() == 0)
            begin
                $error("result of kind %0d arrived with nothing expected", out_data.kind);
                error_count++;
            end
            else
            begin
                want = pending_decodes.pop_front();
                check_field("kind", want.kind, out_data.kind);
                check_field("row", want.row, out_data.row);
                check_field("column", want.column, out_data.column);
                check_field("run_length", want.run_length, out_data.run_length);
                check_field("color", want.color, out_data.color);
                check_field("width", want.width, out_data.width);
                check_field("height", want.height, out_data.height);
                check_field("left_bound", want.left_bound, out_data.left_bound);
                check_field("top_bound", want.top_bound, out_data.top_bound);
            end
        end
    end

    initial
    begin
        in_idle_pct = 22;
        out_idle_pct = 54;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_idle_bytes();
        test_bad_headers();
        test_full_shape();
        test_op_limit();
        test_idle_bytes();
        test_restart();
        test_max_dims();
        test_backpressure();
        test_random(22, 54, 80);
        test_random(54, 22, 80);
        test_random(0, 0, 80);
        in_valid <= 1'b0;
        while (pending_decodes.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        $display("Decoded %0d shape bytes under idle, stall and long hold-off patterns.",
                 bytes_taken);
        $display("Checked %0d headers, %0d pixel runs, %0d completions, %0d errors.",
                 results_seen[KIND_HEADER], results_seen[KIND_RUN],
                 results_seen[KIND_DONE], results_seen[KIND_ERROR]);
        if (error_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
